@@ hw/rtl/cpose_pkg.sv @@
// ----------------------------------------------------------------------------
// cpose_pkg
// Shared types, codes, widths, arctangent table and saturation helpers for the
// camera pose update unit.
// ----------------------------------------------------------------------------
package cpose_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_DEPTH          = 24;
    localparam int ATAN_IDX_W          = 5;
    localparam int CW                  = 18;  // cordic x/y width
    localparam int ZW                  = 34;  // cordic angle accumulator width
    localparam int PW                  = 34;  // rounded product width
    localparam int SUMW                = 35;  // position update width

    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_RAW    = 2'd1;
    localparam logic [1:0] CMD_MOVE   = 2'd2;
    localparam logic [1:0] CMD_ROTATE = 2'd3;

    localparam logic [2:0] DIR_FORWARD  = 3'd0;
    localparam logic [2:0] DIR_BACKWARD = 3'd1;
    localparam logic [2:0] DIR_LEFT     = 3'd2;
    localparam logic [2:0] DIR_RIGHT    = 3'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_INIT = 2'd1;
    localparam logic [1:0] ST_BAD_DIR  = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    localparam logic signed [CW-1:0]   CORDIC_X0    = 18'sd19898;
    localparam logic [15:0]            QUARTER_TURN = 16'h4000;
    localparam logic signed [PW-1:0]   Q15_MAX      = 34'sd32767;
    localparam logic signed [PW-1:0]   Q15_MIN      = -34'sd32768;
    localparam logic signed [SUMW-1:0] POS_MAX      = 35'sd2147483647;
    localparam logic signed [SUMW-1:0] POS_MIN      = -35'sd2147483648;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] speed;
        logic [2:0]         direction;
        logic [15:0]        pitch_in;
        logic [15:0]        yaw_in;
    } t_cmd_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        pitch_out;
        logic [15:0]        yaw_out;
        logic [1:0]         status;
    } t_pose;

    function automatic logic [29:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        logic signed [15:0] r;
        if (v > Q15_MAX) begin
            r = 16'sh7FFF;
        end else if (v < Q15_MIN) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUMW-1:0] v);
        logic signed [31:0] r;
        if (v > POS_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < POS_MIN) begin
            r = -32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic hit32(input logic signed [SUMW-1:0] v);
        return (v > POS_MAX) || (v < POS_MIN);
    endfunction

endpackage

@@ hw/rtl/cpose_cordic.sv @@
// ----------------------------------------------------------------------------
// cpose_cordic
// Iterative CORDIC in rotation mode: one micro-rotation per cycle, Q1.15
// sine and cosine of a 16-bit binary angle, saturated to 16 bits.
// ----------------------------------------------------------------------------
module cpose_cordic #(
    parameter int ITERATIONS = cpose_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);
    import cpose_pkg::*;

    localparam logic [ATAN_IDX_W-1:0] LAST_IDX = ATAN_IDX_W'(ITERATIONS - 1);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_neg;
    logic [ATAN_IDX_W-1:0]   r_idx;
    logic signed [CW-1:0]    r_x, r_y;
    logic signed [ZW-1:0]    r_z;
    logic signed [15:0]      r_cos, r_sin;
    logic signed [CW-1:0]    n_x, n_y;
    logic signed [ZW-1:0]    n_z;
    logic signed [CW-1:0]    w_dx, w_dy, w_xf, w_yf;
    logic signed [ZW-1:0]    w_atan, w_z0;
    logic                    w_flip;
    logic                    w_last;

    // second and third quadrant: turn by a half turn, negate at the end
    assign w_flip = i_angle[15] ^ i_angle[14];
    assign w_z0   = ZW'($signed({i_angle[15] ^ w_flip, i_angle[14:0], 16'h0000}));
    assign w_atan = ZW'($signed({1'b0, atan_entry(r_idx)}));
    assign w_dx   = r_y >>> r_idx;
    assign w_dy   = r_x >>> r_idx;
    assign w_last = (r_idx == LAST_IDX);

    always_comb begin
        if (!r_z[ZW-1]) begin
            n_x = r_x - w_dx;
            n_y = r_y + w_dy;
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + w_dx;
            n_y = r_y - w_dy;
            n_z = r_z + w_atan;
        end
    end

    assign w_xf = r_neg ? -n_x : n_x;
    assign w_yf = r_neg ? -n_y : n_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_x   <= CORDIC_X0;
            r_y   <= '0;
            r_z   <= w_z0;
            r_neg <= w_flip;
            r_idx <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_idx <= r_idx + 1'b1;
            if (w_last) begin
                r_cos <= sat16(PW'(w_xf));
                r_sin <= sat16(PW'(w_yf));
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

@@ hw/rtl/cpose_mul.sv @@
// ----------------------------------------------------------------------------
// cpose_mul
// Shared signed 32x16 multiplier with Q15 rounding, one registered stage.
// ----------------------------------------------------------------------------
module cpose_mul (
    input  logic                           i_clk,
    input  logic signed [31:0]             i_a,
    input  logic signed [15:0]             i_b,
    output logic signed [cpose_pkg::PW-1:0] o_p
);
    import cpose_pkg::*;

    logic signed [47:0]   w_prod;
    logic signed [48:0]   w_rnd;
    logic signed [PW-1:0] r_p;

    assign w_prod = i_a * i_b;
    assign w_rnd  = 49'(w_prod) + 49'sd16384;

    always_ff @(posedge i_clk) begin
        r_p <= w_rnd[PW+14:15];
    end

    assign o_p = r_p;

endmodule

@@ hw/rtl/camera_pose_update_unit.sv @@
// ----------------------------------------------------------------------------
// camera_pose_update_unit
// Euler-angle fly camera pose keeper: init, raw translate, directional move
// and rotate commands, one pose and status per transaction.
//
//   channel  direction  handshake                payload
//   in       to block   i_in_valid / o_in_stall  i_in  (t_cmd_item)
//   out      from block o_out_valid / i_out_stall o_out (t_pose)
//
// init, rotate and rejected commands: result loaded from the done state
// raw translate: position update state, then done
// left/right move: one cordic pass, then M2 to M5, update and done
// forward/backward move: two cordic passes, then M0 to M5, update and done
// i_in is stalled while a transaction is in work or its result waits to load
// synchronous active-low reset clears the pose to zero and not initialised
// ----------------------------------------------------------------------------
module camera_pose_update_unit #(
    parameter int TRIG_ITERATIONS = cpose_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cpose_pkg::t_cmd_item i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cpose_pkg::t_pose     o_out
);
    import cpose_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_C1   = 4'd1;
    localparam logic [3:0] S_C2   = 4'd2;
    localparam logic [3:0] S_M0   = 4'd3;
    localparam logic [3:0] S_M1   = 4'd4;
    localparam logic [3:0] S_M2   = 4'd5;
    localparam logic [3:0] S_M3   = 4'd6;
    localparam logic [3:0] S_M4   = 4'd7;
    localparam logic [3:0] S_M5   = 4'd8;
    localparam logic [3:0] S_UPD  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]           r_state, n_state;
    logic                 r_init;
    logic signed [31:0]   r_pos_x, r_pos_y, r_pos_z;
    logic [15:0]          r_pitch, r_yaw;
    logic [1:0]           r_status;
    logic signed [31:0]   r_speed;
    logic                 r_back, r_side;
    logic signed [15:0]   r_cp, r_nx, r_ny, r_nz;
    logic signed [PW-1:0] r_dx, r_dy, r_dz;
    t_pose                r_out;
    logic                 r_out_valid;

    logic                 w_accept;
    logic                 w_dir_ok;
    logic                 w_slot_free;
    logic                 w_cs;
    logic [15:0]          w_angle, w_first_angle;
    logic                 w_cdone;
    logic signed [15:0]   w_cos, w_sin;
    logic signed [31:0]   w_mul_a;
    logic signed [15:0]   w_mul_b;
    logic signed [PW-1:0] w_mul_p;
    logic signed [SUMW-1:0] w_sx, w_sy, w_sz;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_dir_ok    = !i_in.direction[2];
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        priority if (i_in.direction == DIR_LEFT) begin
            w_first_angle = r_yaw - QUARTER_TURN;
        end else if (i_in.direction == DIR_RIGHT) begin
            w_first_angle = r_yaw + QUARTER_TURN;
        end else begin
            w_first_angle = r_pitch;
        end
    end

    assign w_cs = (w_accept && r_init && (i_in.cmd == CMD_MOVE) && w_dir_ok) ||
                  ((r_state == S_C1) && w_cdone && !r_side);
    assign w_angle = (r_state == S_IDLE) ? w_first_angle : r_yaw;

    cpose_cordic #(
        .ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cs),
        .i_angle (w_angle),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_comb begin
        w_mul_a = r_speed;
        w_mul_b = r_nz;
        unique case (r_state)
            S_M0: begin
                w_mul_a = 32'(r_cp);
                w_mul_b = w_sin;
            end
            S_M1: begin
                w_mul_a = 32'(r_cp);
                w_mul_b = w_cos;
            end
            S_M2:    w_mul_b = r_nx;
            S_M3:    w_mul_b = r_ny;
            default: w_mul_b = r_nz;
        endcase
    end

    cpose_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if ((i_in.cmd == CMD_INIT) || !r_init ||
                                 (i_in.cmd == CMD_ROTATE)) begin
                        n_state = S_DONE;
                    end else if (i_in.cmd == CMD_RAW) begin
                        n_state = S_UPD;
                    end else if (w_dir_ok) begin
                        n_state = S_C1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_C1: begin
                if (w_cdone) begin
                    n_state = r_side ? S_M2 : S_C2;
                end
            end
            S_C2: begin
                if (w_cdone) begin
                    n_state = S_M0;
                end
            end
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_UPD;
            S_UPD:   n_state = S_DONE;
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_sx = SUMW'(r_pos_x) + SUMW'(r_dx);
    assign w_sy = SUMW'(r_pos_y) + SUMW'(r_dy);
    assign w_sz = SUMW'(r_pos_z) + SUMW'(r_dz);

    // control and architectural pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                priority if (i_in.cmd == CMD_INIT) begin
                    r_pos_x  <= i_in.vec_x;
                    r_pos_y  <= i_in.vec_y;
                    r_pos_z  <= i_in.vec_z;
                    r_pitch  <= i_in.pitch_in;
                    r_yaw    <= i_in.yaw_in;
                    r_init   <= 1'b1;
                    r_status <= ST_OK;
                end else if (!r_init) begin
                    r_status <= ST_NOT_INIT;
                end else if (i_in.cmd == CMD_ROTATE) begin
                    r_pitch  <= r_pitch + i_in.pitch_in;
                    r_yaw    <= r_yaw + i_in.yaw_in;
                    r_status <= ST_OK;
                end else if ((i_in.cmd == CMD_MOVE) && !w_dir_ok) begin
                    r_status <= ST_BAD_DIR;
                end else begin
                    r_status <= ST_OK;
                end
            end
            if (r_state == S_UPD) begin
                r_pos_x  <= sat32(w_sx);
                r_pos_y  <= sat32(w_sy);
                r_pos_z  <= sat32(w_sz);
                r_status <= (hit32(w_sx) || hit32(w_sy) || hit32(w_sz)) ? ST_SAT : ST_OK;
            end
            if ((r_state == S_DONE) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction operands and intermediate vectors
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_speed <= i_in.speed;
            r_back  <= (i_in.direction == DIR_BACKWARD);
            r_side  <= (i_in.direction == DIR_LEFT) || (i_in.direction == DIR_RIGHT);
            r_dx    <= -PW'(i_in.vec_x);
            r_dy    <= -PW'(i_in.vec_y);
            r_dz    <= PW'(i_in.vec_z);
        end
        unique case (r_state)
            S_C1: begin
                if (w_cdone) begin
                    if (r_side) begin
                        r_nx <= w_sin;
                        r_ny <= '0;
                        r_nz <= w_cos;
                    end else begin
                        r_cp <= w_cos;
                        r_ny <= w_sin;
                    end
                end
            end
            S_M1: r_nx <= sat16(w_mul_p);
            S_M2: begin
                if (!r_side) begin
                    r_nz <= sat16(w_mul_p);
                end
            end
            S_M3: r_dx <= r_back ? -w_mul_p : w_mul_p;
            S_M4: r_dy <= r_back ? w_mul_p : -w_mul_p;
            S_M5: r_dz <= r_back ? -w_mul_p : w_mul_p;
            default: begin
            end
        endcase
        if ((r_state == S_DONE) && w_slot_free) begin
            r_out.pos_x     <= r_pos_x;
            r_out.pos_y     <= r_pos_y;
            r_out.pos_z     <= r_pos_z;
            r_out.pitch_out <= r_pitch;
            r_out.yaw_out   <= r_yaw;
            r_out.status    <= r_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> ((r_state == S_C1) || (r_state == S_C2)))
        else $error("cordic result outside a cordic wait state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_init && (i_in.cmd != CMD_INIT)) |=> (r_status == ST_NOT_INIT))
        else $error("command before init not flagged");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_init))
        else $error("initialised flag dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_pos_x != $past(r_pos_x))) |->
        (($past(r_state) == S_IDLE) || ($past(r_state) == S_UPD)))
        else $error("position changed outside accept or update");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded without a finished transaction");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for camera_pose_update_unit. A directed table covers
// commands before init, init at the position extremes, saturation, bad
// directions and angle wrap. Random command streams follow. Every returned
// pose is compared with the table's expected pose or with a local fixed-point
// model of the pose update, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import cpose_pkg::*;

    localparam int TRIG_STEPS     = TRIG_ITERATIONS_DEF;
    localparam int RANDOM_ITEMS   = 600;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLDOFF_AT     = 150;
    localparam int HOLDOFF_CYCLES = 300;

    localparam logic [2:0] DIR_BAD_LO = 3'd4;
    localparam logic [2:0] DIR_BAD_HI = 3'd7;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_cmd_item i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_pose     o_out;

    camera_pose_update_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint atan_q32 [0:23] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    logic signed [31:0] cam_x, cam_y, cam_z;
    logic [15:0]        cam_pitch, cam_yaw;
    bit                 cam_ready;

    t_pose     pending_poses[$];
    t_cmd_item row_items[$];
    bit        row_typed[$];
    t_pose     row_poses[$];
    int        mismatches  = 0;
    int        idle_cycles = 0;

    function automatic longint clamp_q15(input longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic logic signed [31:0] clamp_pos(input longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint q15_mul(input longint a, input longint b);
        return (a * b + 16384) >>> 15;
    endfunction

    function automatic void trig_q15(input logic [15:0] ang, output longint c,
                                     output longint s);
        logic [31:0] a;
        longint      x, y, z, dx, dy;
        bit          flip;
        a    = {ang, 16'h0000};
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip) begin
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        x = 19898;
        y = 0;
        for (int i = 0; i < TRIG_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q32[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q32[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp_q15(x);
        s = clamp_q15(y);
    endfunction

    function automatic t_pose update_pose(input t_cmd_item c);
        t_pose       r;
        longint      cp, sp, cy, sy, nx, ny, nz, dx, dy, dz, spd;
        logic [15:0] a;
        logic [1:0]  st;
        bit          hit;
        hit = 1'b0;
        st  = ST_OK;
        if (c.cmd == CMD_INIT) begin
            cam_x     = c.vec_x;
            cam_y     = c.vec_y;
            cam_z     = c.vec_z;
            cam_pitch = c.pitch_in;
            cam_yaw   = c.yaw_in;
            cam_ready = 1'b1;
        end else if (!cam_ready) begin
            st = ST_NOT_INIT;
        end else if (c.cmd == CMD_RAW) begin
            cam_x = clamp_pos(longint'(cam_x) - longint'($signed(c.vec_x)), hit);
            cam_y = clamp_pos(longint'(cam_y) - longint'($signed(c.vec_y)), hit);
            cam_z = clamp_pos(longint'(cam_z) + longint'($signed(c.vec_z)), hit);
        end else if (c.cmd == CMD_MOVE) begin
            if (c.direction > DIR_RIGHT) begin
                st = ST_BAD_DIR;
            end else begin
                if (c.direction == DIR_FORWARD || c.direction == DIR_BACKWARD) begin
                    trig_q15(cam_pitch, cp, sp);
                    trig_q15(cam_yaw, cy, sy);
                    nx = clamp_q15(q15_mul(cp, sy));
                    ny = sp;
                    nz = clamp_q15(q15_mul(cp, cy));
                end else begin
                    a = (c.direction == DIR_LEFT) ? cam_yaw - QUARTER_TURN
                                                  : cam_yaw + QUARTER_TURN;
                    trig_q15(a, nz, nx);
                    ny = 0;
                end
                spd = longint'($signed(c.speed));
                dx  = q15_mul(spd, nx);
                dy  = q15_mul(spd, ny);
                dz  = q15_mul(spd, nz);
                if (c.direction == DIR_BACKWARD) begin
                    dx = -dx;
                    dy = -dy;
                    dz = -dz;
                end
                cam_x = clamp_pos(longint'(cam_x) + dx, hit);
                cam_y = clamp_pos(longint'(cam_y) - dy, hit);
                cam_z = clamp_pos(longint'(cam_z) + dz, hit);
            end
        end else begin
            cam_pitch = cam_pitch + c.pitch_in;
            cam_yaw   = cam_yaw + c.yaw_in;
        end
        if (hit) begin
            st = ST_SAT;
        end
        r.pos_x     = cam_x;
        r.pos_y     = cam_y;
        r.pos_z     = cam_z;
        r.pitch_out = cam_pitch;
        r.yaw_out   = cam_yaw;
        r.status    = st;
        return r;
    endfunction

    function automatic t_cmd_item mk_cmd(input logic [1:0] cmd, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input logic [31:0] spd, input logic [2:0] dir,
                                         input logic [15:0] p, input logic [15:0] yw);
        t_cmd_item c;
        c.cmd       = cmd;
        c.vec_x     = x;
        c.vec_y     = y;
        c.vec_z     = z;
        c.speed     = spd;
        c.direction = dir;
        c.pitch_in  = p;
        c.yaw_in    = yw;
        return c;
    endfunction

    function automatic t_pose mk_pose(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [15:0] p,
                                      input logic [15:0] yw, input logic [1:0] st);
        t_pose r;
        r.pos_x     = x;
        r.pos_y     = y;
        r.pos_z     = z;
        r.pitch_out = p;
        r.yaw_out   = yw;
        r.status    = st;
        return r;
    endfunction

    task automatic add_row(input t_cmd_item item, input bit typed, input t_pose pose);
        row_items.push_back(item);
        row_typed.push_back(typed);
        row_poses.push_back(pose);
    endtask

    function automatic logic [31:0] pick_q16();
        int v;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom;
            2: v = ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
            3: v = int'($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
            default: v = int'($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_angle();
        if ($urandom_range(0, 3) == 0) begin
            return {2'($urandom), 14'h0000};
        end
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch %s: got %h expected %h", $time, field, got, want);
    endtask

    task automatic send_cmd(input t_cmd_item item, input int gap, input bit typed,
                            input t_pose typed_pose);
        t_pose predicted;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = update_pose(item);
        pending_poses.push_back(typed ? typed_pose : predicted);
    endtask

    initial begin
        t_cmd_item item;
        int        gap;
        int        pick;
        cam_x     = '0;
        cam_y     = '0;
        cam_z     = '0;
        cam_pitch = '0;
        cam_yaw   = '0;
        cam_ready = 1'b0;

        add_row(mk_cmd(CMD_RAW, 32'h1, 32'h2, 32'h3, 32'h0, DIR_FORWARD, 16'h0, 16'h0),
                1'b1, mk_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, ST_NOT_INIT));
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, DIR_FORWARD,
                       16'h0, 16'h0),
                1'b1, mk_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, ST_NOT_INIT));
        add_row(mk_cmd(CMD_ROTATE, 32'h0, 32'h0, 32'h0, 32'h0, DIR_FORWARD,
                       16'h1234, 16'h5678),
                1'b1, mk_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, ST_NOT_INIT));
        add_row(mk_cmd(CMD_INIT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0,
                       DIR_FORWARD, 16'hFFFF, 16'h0000),
                1'b1, mk_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF,
                              16'h0000, ST_OK));
        add_row(mk_cmd(CMD_RAW, 32'h80000000, 32'h1, 32'h1, 32'h0, DIR_FORWARD,
                       16'h0, 16'h0),
                1'b1, mk_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF,
                              16'h0000, ST_SAT));
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h00010000, DIR_BAD_LO,
                       16'h0, 16'h0),
                1'b1, mk_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF,
                              16'h0000, ST_BAD_DIR));
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h80000000, DIR_BAD_HI,
                       16'h0, 16'h0),
                1'b1, mk_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF,
                              16'h0000, ST_BAD_DIR));
        add_row(mk_cmd(CMD_ROTATE, 32'h0, 32'h0, 32'h0, 32'h0, DIR_FORWARD,
                       16'h0001, 16'hFFFF),
                1'b1, mk_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0000,
                              16'hFFFF, ST_OK));
        add_row(mk_cmd(CMD_INIT, 32'h0, 32'h0, 32'h0, 32'h0, DIR_FORWARD, 16'h0, 16'h0),
                1'b1, mk_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, ST_OK));
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, DIR_FORWARD,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h80000000, DIR_BACKWARD,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h00010000, DIR_LEFT,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h80000000, DIR_RIGHT,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_ROTATE, 32'h0, 32'h0, 32'h0, 32'h0, DIR_FORWARD,
                       16'h4000, 16'h8000), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h00100000, DIR_FORWARD,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_ROTATE, 32'h0, 32'h0, 32'h0, 32'h0, DIR_FORWARD,
                       16'h8000, 16'h4000), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, DIR_BACKWARD,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'hFFFF0000, DIR_LEFT,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_RAW, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h0,
                       DIR_FORWARD, 16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_INIT, 32'h12345678, 32'hEDCBA987, 32'h00C0FFEE, 32'h0,
                       DIR_FORWARD, 16'h2000, 16'hE000), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, DIR_RIGHT,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_INIT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,
                       DIR_FORWARD, 16'h0000, 16'h4000), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, DIR_FORWARD,
                       16'h0, 16'h0), 1'b0, '0);
        add_row(mk_cmd(CMD_MOVE, 32'h0, 32'h0, 32'h0, 32'h80000000, DIR_FORWARD,
                       16'h0, 16'h0), 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < row_items.size(); n++) begin
            send_cmd(row_items[n], $urandom_range(0, 6), row_typed[n], row_poses[n]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            item.cmd       = 2'($urandom);
            item.vec_x     = $urandom;
            item.vec_y     = $urandom;
            item.vec_z     = $urandom;
            item.speed     = $urandom;
            item.direction = 3'($urandom);
            item.pitch_in  = 16'($urandom);
            item.yaw_in    = 16'($urandom);
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                item.cmd      = CMD_INIT;
                item.vec_x    = pick_q16();
                item.vec_y    = pick_q16();
                item.vec_z    = pick_q16();
                item.pitch_in = pick_angle();
                item.yaw_in   = pick_angle();
            end else if (pick < 6) begin
                item.cmd   = CMD_RAW;
                item.vec_x = pick_q16();
                item.vec_y = pick_q16();
                item.vec_z = pick_q16();
            end else if (pick < 15) begin
                item.cmd   = CMD_MOVE;
                item.speed = pick_q16();
                if ($urandom_range(0, 9) == 0) begin
                    item.direction = 3'($urandom_range(DIR_BAD_LO, DIR_BAD_HI));
                end else begin
                    item.direction = 3'($urandom_range(DIR_FORWARD, DIR_RIGHT));
                end
            end else begin
                item.cmd      = CMD_ROTATE;
                item.pitch_in = pick_angle();
                item.yaw_in   = pick_angle();
            end
            gap = ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 6);
            send_cmd(item, gap, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // receiver: random stall per transaction, one long hold-off to back up the input
    initial begin
        int hold;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == HOLDOFF_AT && !held) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            hold = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_poses.size() == 0) begin
                report_mismatch("unexpected transaction, pos_x", o_out.pos_x, 32'h0);
            end else begin
                want = pending_poses.pop_front();
                if (o_out.pos_x !== want.pos_x) begin
                    report_mismatch("pos_x", o_out.pos_x, want.pos_x);
                end
                if (o_out.pos_y !== want.pos_y) begin
                    report_mismatch("pos_y", o_out.pos_y, want.pos_y);
                end
                if (o_out.pos_z !== want.pos_z) begin
                    report_mismatch("pos_z", o_out.pos_z, want.pos_z);
                end
                if (o_out.pitch_out !== want.pitch_out) begin
                    report_mismatch("pitch_out", 32'(o_out.pitch_out), 32'(want.pitch_out));
                end
                if (o_out.yaw_out !== want.yaw_out) begin
                    report_mismatch("yaw_out", 32'(o_out.yaw_out), 32'(want.yaw_out));
                end
                if (o_out.status !== want.status) begin
                    report_mismatch("status", 32'(o_out.status), 32'(want.status));
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

@@ camera_pose_update_unit.f @@
hw/rtl/cpose_pkg.sv
hw/rtl/cpose_cordic.sv
hw/rtl/cpose_mul.sv
hw/rtl/camera_pose_update_unit.sv
tb/tb_top.sv
